FILE: src/flv_tag_stream_splicer_assert.svh
`ifndef FLV_TAG_STREAM_SPLICER_ASSERT_SVH
`define FLV_TAG_STREAM_SPLICER_ASSERT_SVH

// check a property while out of reset
`define FLV_TSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// check a property that covers reset itself
`define FLV_TSS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: src/flv_tss_pkg.sv
package flv_tss_pkg;

  localparam int TAG_HDR_BYTES  = 15;
  localparam int FILE_HDR_BYTES = 9;

  localparam logic [3:0] HDR_LAST      = 4'(TAG_HDR_BYTES - 1);
  localparam logic [3:0] FILE_HDR_LAST = 4'(FILE_HDR_BYTES - 1);
  localparam logic [7:0] SCRIPT_TYPE   = 8'd18;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic CFG_TS_OFFSET  = 1'b0;
  localparam logic CFG_FIRST_PREV = 1'b1;

  typedef enum logic [2:0] {
    PH_FILE_HDR,
    PH_SEEK_HDR,
    PH_SEEK_PAY,
    PH_SCRIPT_PAY,
    PH_EXTRA_HDR,
    PH_EXTRA_PAY,
    PH_EMIT_HDR,
    PH_EMIT_PAY
  } phase_t;

  typedef struct packed {
    logic        res;
    logic        hdr;
    logic        kind;
    logic        last;
    logic [7:0]  data;
    logic [31:0] size;
  } ev_t;

  function automatic phase_t after_payload(phase_t ph, logic fps_nz, logic [1:0] extra);
    phase_t r;
    unique case (ph)
      PH_SEEK_PAY:   r = PH_SEEK_HDR;
      PH_SCRIPT_PAY: r = fps_nz ? PH_EXTRA_HDR : PH_EMIT_HDR;
      PH_EXTRA_PAY:  r = (extra >= 2'd2) ? PH_EMIT_HDR : PH_EXTRA_HDR;
      default:       r = PH_EMIT_HDR;
    endcase
    return r;
  endfunction

endpackage

FILE: src/flv_tss_parser.sv
module flv_tss_parser
  import flv_tss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        acc,
  input  logic        func,
  input  logic [7:0]  in_byte,
  input  logic [31:0] ts_offset,
  input  logic [31:0] first_prev,
  input  logic [3:0]  rd_idx,
  output ev_t         ev,
  output logic [7:0]  rd_byte
);

  phase_t      phase, phase_next;
  logic [7:0]  header_store [TAG_HDR_BYTES];
  logic [7:0]  hs_next [TAG_HDR_BYTES];
  logic [3:0]  byte_index, byte_index_next;
  logic [23:0] payload_left, payload_left_next;
  logic [1:0]  extra, extra_next;
  logic        emitted, emitted_next;

  assign rd_byte = header_store[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FILE_HDR;
      byte_index   <= '0;
      payload_left <= '0;
      extra        <= '0;
      emitted      <= 1'b0;
    end else begin
      phase        <= phase_next;
      byte_index   <= byte_index_next;
      payload_left <= payload_left_next;
      extra        <= extra_next;
      emitted      <= emitted_next;
    end
  end

  always_ff @(posedge clk) begin
    header_store <= hs_next;
  end

  always_comb begin
    logic [3:0]  idx;
    logic        full;
    logic [23:0] size_in;
    logic [23:0] pl_dec;
    logic [31:0] ts_sum;
    logic [1:0]  ex_upd;
    phase_t      pay_ph;
    phase_t      end_ph;
    logic        fps_nz;

    phase_next        = phase;
    byte_index_next   = byte_index;
    payload_left_next = payload_left;
    extra_next        = extra;
    emitted_next      = emitted;
    hs_next           = header_store;
    ev                = '0;

    idx     = (byte_index >= HDR_LAST + 4'd1) ? 4'd0 : byte_index;
    full    = (idx == HDR_LAST);
    size_in = {header_store[5], header_store[6], header_store[7]};
    ts_sum  = {header_store[11], header_store[8], header_store[9], header_store[10]}
              + ts_offset;
    fps_nz  = (first_prev != 32'd0);
    pl_dec  = (payload_left == 24'd0) ? 24'd0 : payload_left - 24'd1;
    ex_upd  = (extra < 2'd2) ? extra + 2'd1 : extra;
    pay_ph  = PH_SEEK_PAY;
    end_ph  = PH_EMIT_HDR;

    if (acc) begin
      if (func == FUNC_END) begin
        ev.res  = 1'b1;
        ev.kind = KIND_END;
        ev.last = 1'b1;
        ev.size = emitted ? {header_store[0], header_store[1], header_store[2],
                             header_store[3]} : 32'd0;
        phase_next        = PH_FILE_HDR;
        byte_index_next   = '0;
        payload_left_next = '0;
        extra_next        = '0;
        emitted_next      = 1'b0;
      end else begin
        unique case (phase)
          PH_FILE_HDR: begin
            if (byte_index >= FILE_HDR_LAST) begin
              byte_index_next = '0;
              phase_next      = PH_SEEK_HDR;
            end else begin
              byte_index_next = byte_index + 4'd1;
            end
          end
          PH_SEEK_HDR, PH_EXTRA_HDR, PH_EMIT_HDR: begin
            hs_next[idx]    = in_byte;
            byte_index_next = full ? 4'd0 : idx + 4'd1;
            if (full) begin
              unique case (phase)
                PH_SEEK_HDR:
                  pay_ph = (header_store[4] == SCRIPT_TYPE) ? PH_SCRIPT_PAY : PH_SEEK_PAY;
                PH_EXTRA_HDR: begin
                  pay_ph     = PH_EXTRA_PAY;
                  extra_next = ex_upd;
                end
                default: begin
                  pay_ph = PH_EMIT_PAY;
                  if (!emitted) begin
                    hs_next[0] = first_prev[31:24];
                    hs_next[1] = first_prev[23:16];
                    hs_next[2] = first_prev[15:8];
                    hs_next[3] = first_prev[7:0];
                  end
                  hs_next[8]   = ts_sum[23:16];
                  hs_next[9]   = ts_sum[15:8];
                  hs_next[10]  = ts_sum[7:0];
                  hs_next[11]  = ts_sum[31:24];
                  emitted_next = 1'b1;
                  ev.res  = 1'b1;
                  ev.hdr  = 1'b1;
                  ev.kind = KIND_BYTE;
                  ev.data = hs_next[0];
                end
              endcase
              payload_left_next = size_in;
              if (size_in == 24'd0) begin
                end_ph     = after_payload(pay_ph, fps_nz, extra_next);
                phase_next = end_ph;
                if (pay_ph == PH_SCRIPT_PAY && fps_nz) extra_next = '0;
              end else begin
                phase_next = pay_ph;
              end
            end
          end
          default: begin
            if (phase == PH_EMIT_PAY) begin
              ev.res  = 1'b1;
              ev.kind = KIND_BYTE;
              ev.last = 1'b1;
              ev.data = in_byte;
            end
            payload_left_next = pl_dec;
            if (pl_dec == 24'd0) begin
              end_ph     = after_payload(phase, fps_nz, extra);
              phase_next = end_ph;
              if (phase == PH_SCRIPT_PAY && fps_nz) extra_next = '0;
            end
          end
        endcase
      end
    end
  end

endmodule

FILE: src/flv_tag_stream_splicer.sv
// channel   direction  handshake            payload
// input     in         in_valid / in_stall  func, in_byte
// output    out        out_valid/out_stall  out_kind, out_byte, final_size, run_last
// config    in         wr_en                wr_index, wr_data
//
// One input byte per cycle while in_stall is low, skipped and payload bytes alike.
// A byte that completes an emitted tag header yields 15 output bytes, one per
// cycle from the header store while out_stall is low; input stalls until the last is sent.
// Input also stalls while a result sits in the output register under out_stall.
// rst is synchronous and clears the parse state at once; an end marker returns
// the stream state to its reset values while the registers keep theirs.
`include "flv_tag_stream_splicer_assert.svh"

module flv_tag_stream_splicer
  import flv_tss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [31:0] wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic [31:0] final_size,
  output logic        run_last
);

  logic [31:0] ts_offset;
  logic [31:0] first_prev;
  logic        burst;
  logic [3:0]  bidx;
  logic        out_free;
  logic        in_acc;
  ev_t         ev;
  logic [7:0]  rd_byte;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = burst || !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ts_offset  <= '0;
      first_prev <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_TS_OFFSET:  ts_offset  <= wr_data;
        CFG_FIRST_PREV: first_prev <= wr_data;
        default:        ts_offset  <= ts_offset;
      endcase
    end
  end

  flv_tss_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .acc        (in_acc),
    .func       (func),
    .in_byte    (in_byte),
    .ts_offset  (ts_offset),
    .first_prev (first_prev),
    .rd_idx     (bidx),
    .ev         (ev),
    .rd_byte    (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      burst     <= 1'b0;
      bidx      <= '0;
    end else if (in_acc && ev.res) begin
      out_valid <= 1'b1;
      burst     <= ev.hdr;
      bidx      <= 4'd1;
    end else if (burst && out_free) begin
      out_valid <= 1'b1;
      bidx      <= bidx + 4'd1;
      if (bidx == HDR_LAST) burst <= 1'b0;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && ev.res) begin
      out_kind   <= ev.kind;
      out_byte   <= ev.data;
      final_size <= ev.size;
      run_last   <= ev.last;
    end else if (burst && out_free) begin
      out_kind   <= KIND_BYTE;
      out_byte   <= rd_byte;
      final_size <= '0;
      run_last   <= (bidx == HDR_LAST);
    end
  end

  `FLV_TSS_ASSERT(a_end_report, (in_acc && func == FUNC_END) |=> (out_valid && out_kind == KIND_END && run_last), "end marker gave no report")
  `FLV_TSS_ASSERT(a_burst_pending, burst |-> (out_valid && !run_last && out_kind == KIND_BYTE), "header burst without pending header byte")
  `FLV_TSS_ASSERT(a_burst_steps, (burst && !out_stall) |=> (out_valid && bidx == $past(bidx) + 4'd1), "header burst did not advance")
  `FLV_TSS_ASSERT(a_byte_size, (out_valid && out_kind == KIND_BYTE) |-> (final_size == 32'd0), "stream byte carries a size")
  `FLV_TSS_ASSERT_RST(a_reset_idle, rst |=> (!out_valid && !burst), "output not idle after reset")

endmodule
